FILE: rtl/ffba_pkg.sv
`timescale 1ns / 1ps

package ffba_pkg;

    // Fixed field widths
    localparam int ADDR_W = 32;
    localparam int REQ_W  = 24;
    localparam int HDR_W  = 7;
    localparam int CFG_W  = 32;
    localparam int STAT_W = 3;

    // The shared adder carries two guard bits so that carries and borrows stay visible
    localparam int ALU_W  = ADDR_W + 2;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_BLOCKS = 64;
    localparam int DEF_SIZE_BITS  = 24;

    // Configuration register indexes
    localparam logic [1:0] CFG_HEAP_BASE    = 2'd0;
    localparam logic [1:0] CFG_HEAP_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_HEADER_BYTES = 2'd2;

    // Configuration reset values
    localparam logic [ADDR_W-1:0] RST_HEAP_BASE    = 32'd65536;
    localparam logic [ADDR_W-1:0] RST_HEAP_LIMIT   = 32'hFFFF_FFFF;
    localparam logic [HDR_W-1:0]  RST_HEADER_BYTES = 7'd24;

    // Request kinds
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_REUSED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_NEW     = 3'd1;
    localparam logic [STAT_W-1:0] ST_ZERO    = 3'd2;
    localparam logic [STAT_W-1:0] ST_OOM     = 3'd3;
    localparam logic [STAT_W-1:0] ST_TAIL    = 3'd4;
    localparam logic [STAT_W-1:0] ST_MARKED  = 3'd5;
    localparam logic [STAT_W-1:0] ST_BADFREE = 3'd6;

    // Operation handed to the shared adder
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

endpackage

FILE: rtl/ffba_alu.sv
`timescale 1ns / 1ps

module ffba_alu
    import ffba_pkg::*;
(
    input  alu_req_t         req,
    output logic [ALU_W-1:0] res
);

    // Add, or subtract by adding the inverted operand plus one
    always_comb
    begin
        res = req.a + (req.sub ? ~req.b : req.b) + ALU_W'(req.sub);
    end

endmodule

FILE: rtl/ffba_table.sv
`timescale 1ns / 1ps

module ffba_table #(
    parameter int DEPTH = 64,
    parameter int ENT_W = 57
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [ENT_W-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [ENT_W-1:0]         rdata
);

    logic [ENT_W-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// Flow: a zero-size, oversized or null-free request goes from acceptance straight to hand-over (S_DONE).
// A table search reads each entry visited (S_RD), then checks it in the shared adder (S_CHK);
// an allocation with no fit then takes the append path (S_ADD1, S_ADD2, S_CMPL) to hand-over.
// Throughput: one request at a time; a new transaction is taken only when the sequencer is idle.
// Reset: block count clears, break returns to heap_base, registers to their defaults; the table
// itself is not cleared, as only entries below the block count are ever read.

module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic                func,
    input  logic [REQ_W-1:0]    request_size,
    input  logic [ADDR_W-1:0]   data_address,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [ADDR_W-1:0]   result_address,
    output logic [STAT_W-1:0]   status
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int ENT_W = ADDR_W + SIZE_BITS + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TGT,
        S_RD,
        S_CHK,
        S_RADD,
        S_ADD1,
        S_ADD2,
        S_CMPL,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [ADDR_W-1:0]   limit_reg, limit_next;
    logic [HDR_W-1:0]    hdr_reg, hdr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   break_reg, break_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                func_reg, func_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [ADDR_W-1:0]   target_reg, target_next;
    logic [ADDR_W-1:0]   hit_start_reg, hit_start_next;
    logic [ALU_W-1:0]    tmp_reg, tmp_next;
    logic [ALU_W-1:0]    end_reg, end_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic [STAT_W-1:0]   res_stat_reg, res_stat_next;
    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [STAT_W-1:0]   out_stat_reg, out_stat_next;

    alu_req_t            alu_req;
    logic [ALU_W-1:0]    alu_res;

    logic                tbl_we;
    logic [IDX_W-1:0]    tbl_waddr;
    logic [ENT_W-1:0]    tbl_wdata;
    logic [ENT_W-1:0]    tbl_rdata;

    logic [ADDR_W-1:0]   rd_start;
    logic [SIZE_BITS-1:0] rd_size;
    logic                rd_free;
    logic                last_entry;
    logic                in_take;
    logic                oversize;

    ffba_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    ffba_table #(
        .DEPTH (MAX_BLOCKS),
        .ENT_W (ENT_W)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (tbl_rdata)
    );

    // Split the entry read back from the table
    assign rd_start   = tbl_rdata[ENT_W-1 -: ADDR_W];
    assign rd_size    = tbl_rdata[SIZE_BITS:1];
    assign rd_free    = tbl_rdata[0];
    assign last_entry = (CNT_W'(idx_reg + 1'b1) == count_reg);

    assign in_stall   = (state_reg != S_IDLE);
    assign in_take    = in_valid && !in_stall;
    assign oversize   = ((ALU_W'(request_size) >> SIZE_BITS) != '0);

    assign out_valid      = out_valid_reg;
    assign result_address = out_addr_reg;
    assign status         = out_stat_reg;

    // Select the operands of the shared adder for each step
    always_comb
    begin
        alu_req = '0;
        case (state_reg)
            S_TGT:
            begin
                alu_req.a   = ALU_W'(addr_reg);
                alu_req.b   = ALU_W'(hdr_reg);
                alu_req.sub = 1'b1;
            end
            S_CHK:
            begin
                alu_req.a   = ALU_W'(rd_size);
                alu_req.b   = ALU_W'(req_reg);
                alu_req.sub = 1'b1;
            end
            S_RADD:
            begin
                alu_req.a = ALU_W'(hit_start_reg);
                alu_req.b = ALU_W'(hdr_reg);
            end
            S_ADD1:
            begin
                alu_req.a = ALU_W'(break_reg);
                alu_req.b = ALU_W'(hdr_reg);
            end
            S_ADD2:
            begin
                alu_req.a = tmp_reg;
                alu_req.b = ALU_W'(req_reg);
            end
            S_CMPL:
            begin
                alu_req.a   = ALU_W'(limit_reg);
                alu_req.b   = ALU_W'(end_reg[ADDR_W-1:0]);
                alu_req.sub = 1'b1;
            end
            default:
            begin
                alu_req = '0;
            end
        endcase
    end

    // Sequencer and register next values
    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        limit_next     = limit_reg;
        hdr_next       = hdr_reg;
        count_next     = count_reg;
        break_next     = break_reg;
        idx_next       = idx_reg;
        func_next      = func_reg;
        req_next       = req_reg;
        addr_next      = addr_reg;
        target_next    = target_reg;
        hit_start_next = hit_start_reg;
        tmp_next       = tmp_reg;
        end_next       = end_reg;
        res_addr_next  = res_addr_reg;
        res_stat_next  = res_stat_reg;
        out_valid_next = out_valid_reg;
        out_addr_next  = out_addr_reg;
        out_stat_next  = out_stat_reg;
        tbl_we         = 1'b0;
        tbl_waddr      = idx_reg[IDX_W-1:0];
        tbl_wdata      = {rd_start, rd_size, rd_free};

        // Drop the result once the far side has taken it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Configuration writes
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_HEAP_BASE:
                begin
                    base_next = cfg_data;
                    if (count_reg == '0)
                    begin
                        break_next = cfg_data;
                    end
                end
                CFG_HEAP_LIMIT:
                begin
                    limit_next = cfg_data;
                end
                CFG_HEADER_BYTES:
                begin
                    hdr_next = cfg_data[HDR_W-1:0];
                end
                default:
                begin
                    hdr_next = hdr_reg;
                end
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    func_next     = func;
                    req_next      = request_size;
                    addr_next     = data_address;
                    idx_next      = '0;
                    res_addr_next = '0;
                    if (func == FUNC_ALLOC)
                    begin
                        if (request_size == '0)
                        begin
                            res_stat_next = ST_ZERO;
                            state_next    = S_DONE;
                        end
                        else if (oversize)
                        begin
                            res_stat_next = ST_OOM;
                            state_next    = S_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = S_ADD1;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        if (data_address == '0)
                        begin
                            res_stat_next = ST_BADFREE;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            state_next = S_TGT;
                        end
                    end
                end
            end

            // Work out the header address that the freed data address implies
            S_TGT:
            begin
                target_next = alu_res[ADDR_W-1:0];
                if (count_reg == '0)
                begin
                    res_stat_next = ST_BADFREE;
                    state_next    = S_DONE;
                end
                else
                begin
                    state_next = S_RD;
                end
            end

            S_RD:
            begin
                state_next = S_CHK;
            end

            // Test one table entry
            S_CHK:
            begin
                if (func_reg == FUNC_ALLOC)
                begin
                    if (rd_free && !alu_res[ALU_W-1])
                    begin
                        tbl_we         = 1'b1;
                        tbl_wdata      = {rd_start, rd_size, 1'b0};
                        hit_start_next = rd_start;
                        state_next     = S_RADD;
                    end
                    else if (last_entry)
                    begin
                        state_next = S_ADD1;
                    end
                    else
                    begin
                        idx_next   = CNT_W'(idx_reg + 1'b1);
                        state_next = S_RD;
                    end
                end
                else
                begin
                    if (rd_start == target_reg)
                    begin
                        if (last_entry)
                        begin
                            break_next    = rd_start;
                            count_next    = CNT_W'(count_reg - 1'b1);
                            res_stat_next = ST_TAIL;
                        end
                        else
                        begin
                            tbl_we        = 1'b1;
                            tbl_wdata     = {rd_start, rd_size, 1'b1};
                            res_stat_next = ST_MARKED;
                        end
                        state_next = S_DONE;
                    end
                    else if (last_entry)
                    begin
                        res_stat_next = ST_BADFREE;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        idx_next   = CNT_W'(idx_reg + 1'b1);
                        state_next = S_RD;
                    end
                end
            end

            // Data address of the reused block
            S_RADD:
            begin
                res_addr_next = alu_res[ADDR_W-1:0];
                res_stat_next = ST_REUSED;
                state_next    = S_DONE;
            end

            // Append path: break plus header with a full-table test, then plus request, then limit test
            S_ADD1:
            begin
                tmp_next = alu_res;
                if (count_reg == CNT_W'(MAX_BLOCKS))
                begin
                    res_stat_next = ST_OOM;
                    state_next    = S_DONE;
                end
                else
                begin
                    state_next = S_ADD2;
                end
            end

            S_ADD2:
            begin
                end_next   = alu_res;
                state_next = S_CMPL;
            end

            S_CMPL:
            begin
                if ((end_reg[ALU_W-1:ADDR_W] != '0) || alu_res[ALU_W-1])
                begin
                    res_stat_next = ST_OOM;
                end
                else
                begin
                    tbl_we        = 1'b1;
                    tbl_waddr     = count_reg[IDX_W-1:0];
                    tbl_wdata     = {break_reg, SIZE_BITS'(req_reg), 1'b0};
                    res_addr_next = tmp_reg[ADDR_W-1:0];
                    res_stat_next = ST_NEW;
                    break_next    = end_reg[ADDR_W-1:0];
                    count_next    = CNT_W'(count_reg + 1'b1);
                end
                state_next = S_DONE;
            end

            // Hand the result over once the output register is free
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = res_addr_reg;
                    out_stat_next  = res_stat_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= RST_HEAP_BASE;
            limit_reg     <= RST_HEAP_LIMIT;
            hdr_reg       <= RST_HEADER_BYTES;
            count_reg     <= '0;
            break_reg     <= RST_HEAP_BASE;
            idx_reg       <= '0;
            func_reg      <= FUNC_ALLOC;
            req_reg       <= '0;
            addr_reg      <= '0;
            target_reg    <= '0;
            hit_start_reg <= '0;
            tmp_reg       <= '0;
            end_reg       <= '0;
            res_addr_reg  <= '0;
            res_stat_reg  <= ST_ZERO;
            out_valid_reg <= 1'b0;
            out_addr_reg  <= '0;
            out_stat_reg  <= ST_ZERO;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            limit_reg     <= limit_next;
            hdr_reg       <= hdr_next;
            count_reg     <= count_next;
            break_reg     <= break_next;
            idx_reg       <= idx_next;
            func_reg      <= func_next;
            req_reg       <= req_next;
            addr_reg      <= addr_next;
            target_reg    <= target_next;
            hit_start_reg <= hit_start_next;
            tmp_reg       <= tmp_next;
            end_reg       <= end_next;
            res_addr_reg  <= res_addr_next;
            res_stat_reg  <= res_stat_next;
            out_valid_reg <= out_valid_next;
            out_addr_reg  <= out_addr_next;
            out_stat_reg  <= out_stat_next;
        end
    end

`ifndef SYNTHESIS
    // The block count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count beyond table depth");

    // A new result appears only from the hand-over step
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside hand-over");

    // The table is written only at or below the current block count
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> (CNT_W'(tbl_waddr) <= count_reg))
        else $error("table write beyond block count");

    // The block count moves only on a tail pop or an append
    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> ($past(state_reg == S_CHK) || $past(state_reg == S_CMPL)))
        else $error("block count changed outside table update");
`endif

endmodule

FILE: verif/ffba_checker.sv
`timescale 1ns / 1ps

module ffba_checker
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,

    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                func,
    input  logic [REQ_W-1:0]    request_size,
    input  logic [ADDR_W-1:0]   data_address,

    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [ADDR_W-1:0]   result_address,
    input  logic [STAT_W-1:0]   status,

    output int                  mismatches,
    output int                  outstanding
);

    localparam logic [63:0] SIZE_MAX = (64'd1 << SIZE_BITS) - 64'd1;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [STAT_W-1:0] code;
    } grant_t;

    // Mirror of the block table, break and registers
    logic [ADDR_W-1:0] blk_start [MAX_BLOCKS];
    logic [31:0]       blk_size  [MAX_BLOCKS];
    logic              blk_free  [MAX_BLOCKS];
    int                blk_count;
    logic [ADDR_W-1:0] brk;
    logic [ADDR_W-1:0] heap_base;
    logic [ADDR_W-1:0] heap_limit;
    logic [HDR_W-1:0]  hdr_bytes;

    // Grants predicted but not yet seen on the result channel
    grant_t grants_due [$];

    // Serve one request against the mirror and return the grant it should produce
    function automatic grant_t serve_request(input logic kind,
                                             input logic [REQ_W-1:0] req,
                                             input logic [ADDR_W-1:0] addr);
        grant_t      g;
        logic [63:0] grow_end;
        bit          found;
        g.address = '0;
        found     = 1'b0;
        if (kind == FUNC_ALLOC) begin
            if (req == '0) begin
                g.code = ST_ZERO;
            end
            else if (64'(req) > SIZE_MAX) begin
                g.code = ST_OOM;
            end
            else begin
                // first fit, reused whole
                for (int i = 0; i < blk_count; i++) begin
                    if (!found && blk_free[i] && blk_size[i] >= 32'(req)) begin
                        found       = 1'b1;
                        blk_free[i] = 1'b0;
                        g.address   = blk_start[i] + 32'(hdr_bytes);
                        g.code      = ST_REUSED;
                    end
                end
                if (!found) begin
                    grow_end = 64'(brk) + 64'(hdr_bytes) + 64'(req);
                    if (blk_count >= MAX_BLOCKS || grow_end > 64'(heap_limit) ||
                        grow_end > 64'hFFFF_FFFF) begin
                        g.code = ST_OOM;
                    end
                    else begin
                        blk_start[blk_count] = brk;
                        blk_size[blk_count]  = 32'(req);
                        blk_free[blk_count]  = 1'b0;
                        g.address            = brk + 32'(hdr_bytes);
                        g.code               = ST_NEW;
                        blk_count++;
                        brk = grow_end[31:0];
                    end
                end
            end
        end
        else begin
            g.code = ST_BADFREE;
            if (addr != '0) begin
                for (int i = 0; i < blk_count; i++) begin
                    if (!found && blk_start[i] + 32'(hdr_bytes) == addr) begin
                        found = 1'b1;
                        if (i + 1 == blk_count) begin
                            // pop the tail and lower the break
                            brk = blk_start[i];
                            blk_count--;
                            g.code = ST_TAIL;
                        end
                        else begin
                            blk_free[i] = 1'b1;
                            g.code      = ST_MARKED;
                        end
                    end
                end
            end
        end
        return g;
    endfunction

    // Track register writes, predict on each accepted request, compare each accepted result
    always @(posedge clk or negedge rst_n)
    begin : watch
        grant_t due;
        if (!rst_n) begin
            heap_base   = RST_HEAP_BASE;
            heap_limit  = RST_HEAP_LIMIT;
            hdr_bytes   = RST_HEADER_BYTES;
            brk         = RST_HEAP_BASE;
            blk_count   = 0;
            grants_due.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else begin
            if (cfg_write) begin
                case (cfg_index)
                    CFG_HEAP_BASE:
                    begin
                        heap_base = cfg_data;
                        if (blk_count == 0)
                            brk = cfg_data;
                    end
                    CFG_HEAP_LIMIT:   heap_limit = cfg_data;
                    CFG_HEADER_BYTES: hdr_bytes  = cfg_data[HDR_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                grants_due.push_back(serve_request(func, request_size, data_address));

            if (out_valid && !out_stall) begin
                if (grants_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected transaction: result_address %h status %0d",
                             $time, result_address, status);
                end
                else begin
                    due = grants_due.pop_front();
                    if (result_address !== due.address) begin
                        mismatches++;
                        $display("%0t: result_address mismatch: expected %h, actual %h",
                                 $time, due.address, result_address);
                    end
                    if (status !== due.code) begin
                        mismatches++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, due.code, status);
                    end
                end
            end
            outstanding = grants_due.size();
        end
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ffba_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    // worst-case search over a full table plus the append path, with margin
    localparam int SETTLE_CYCLES = 2 * DEF_MAX_BLOCKS + 8;

    logic                clk;
    logic                rst_n;
    logic                cfg_write;
    logic [1:0]          cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic                func;
    logic [REQ_W-1:0]    request_size;
    logic [ADDR_W-1:0]   data_address;
    logic                out_valid;
    logic                out_stall;
    logic [ADDR_W-1:0]   result_address;
    logic [STAT_W-1:0]   status;

    int                  mismatches;
    int                  outstanding;
    int                  cycles;
    logic                calm;
    logic [HDR_W-1:0]    cur_hdr;
    // header addresses of every block granted as new since the heap was last emptied
    logic [ADDR_W-1:0]   known_starts [$];

    first_fit_block_allocator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .request_size   (request_size),
        .data_address   (data_address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_address (result_address),
        .status         (status)
    );

    ffba_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .request_size   (request_size),
        .data_address   (data_address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_address (result_address),
        .status         (status),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stall the result channel at random, except in calm stretches
    always @(negedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 27);
    end

    // Record where new blocks land so that frees can target live blocks
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall && status == ST_NEW)
            known_starts.push_back(result_address - 32'(cur_hdr));
    end

    // Offer one request; called and returning at a falling edge
    task automatic send_request(input logic kind, input logic [REQ_W-1:0] req,
                                input logic [ADDR_W-1:0] addr);
        while (!calm && $urandom_range(99) < 27) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        func         <= kind;
        request_size <= req;
        data_address <= addr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold off until every predicted result has come back, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        if (idx == CFG_HEADER_BYTES)
            cur_hdr = val[HDR_W-1:0];
    endtask

    function automatic logic [REQ_W-1:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return '0;
        else if (r < 7)
            return '1;
        else if (r < 75)
            return REQ_W'($urandom_range(64, 1));
        else if (r < 92)
            return REQ_W'($urandom_range(4096, 65));
        else
            return REQ_W'($urandom);
    endfunction

    // Free every recorded block, highest first, so that each one is the tail when freed
    task automatic empty_heap();
        logic [ADDR_W-1:0] order [$];
        wait_idle();
        order = known_starts;
        order.rsort();
        foreach (order[k])
            if (k == 0 || order[k] != order[k-1])
                send_request(FUNC_FREE, pick_size(), order[k] + 32'(cur_hdr));
        wait_idle();
        known_starts.delete();
    endtask

    // Mostly allocations and frees of live blocks; the rest null and stray frees
    task automatic random_request(input int alloc_pct);
        int                r;
        int                n;
        logic [ADDR_W-1:0] addr;
        n = known_starts.size();
        r = $urandom_range(99);
        if ($urandom_range(99) < alloc_pct) begin
            send_request(FUNC_ALLOC, pick_size(), $urandom);
        end
        else begin
            if (r < 5)
                addr = '0;
            else if (r < 12 || n == 0)
                addr = $urandom;
            else if (r < 55)
                addr = known_starts[n - 1 - $urandom_range(n < 8 ? n - 1 : 7)]
                       + 32'(cur_hdr);
            else
                addr = known_starts[$urandom_range(n - 1)] + 32'(cur_hdr);
            send_request(FUNC_FREE, pick_size(), addr);
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] hdr, input logic [CFG_W-1:0] base,
                             input logic [CFG_W-1:0] limit, input int count,
                             input int alloc_pct, input int calm_from, input int calm_to);
        write_reg(CFG_HEADER_BYTES, hdr);
        empty_heap();
        write_reg(CFG_HEAP_BASE, base);
        write_reg(CFG_HEAP_LIMIT, limit);
        for (int k = 0; k < count; k++) begin
            calm = (k >= calm_from && k < calm_to);
            random_request(alloc_pct);
        end
        calm = 1'b0;
        wait_idle();
    endtask

    // Directed pass on the reset configuration
    task automatic directed_checks();
        logic [ADDR_W-1:0] a1, a2, a3, b, c;
        // zero size, then three new blocks including the largest size
        send_request(FUNC_ALLOC, '0, '0);
        send_request(FUNC_ALLOC, REQ_W'(1), $urandom);
        send_request(FUNC_ALLOC, '1, '1);
        send_request(FUNC_ALLOC, REQ_W'(16), '0);
        // null and unknown frees
        send_request(FUNC_FREE, '1, '0);
        send_request(FUNC_FREE, '0, '1);
        wait_idle();
        a1 = known_starts[0] + 32'(cur_hdr);
        a2 = known_starts[1] + 32'(cur_hdr);
        a3 = known_starts[2] + 32'(cur_hdr);
        // mark the middle block free twice, then reuse it whole
        send_request(FUNC_FREE, '0, a2);
        send_request(FUNC_FREE, '0, a2);
        send_request(FUNC_ALLOC, REQ_W'(100), '0);
        // mark the first, then pop from the tail down, the last pop a double free
        send_request(FUNC_FREE, '0, a1);
        send_request(FUNC_FREE, '0, a3);
        send_request(FUNC_FREE, '0, a2);
        send_request(FUNC_FREE, '0, a1);
        send_request(FUNC_FREE, '0, a1);
        // free block before a popped tail stays; new growth starts at the popped block
        send_request(FUNC_ALLOC, REQ_W'(8), '0);
        send_request(FUNC_ALLOC, REQ_W'(8), '0);
        send_request(FUNC_ALLOC, REQ_W'(8), '0);
        wait_idle();
        b = known_starts[4] + 32'(cur_hdr);
        c = known_starts[5] + 32'(cur_hdr);
        send_request(FUNC_FREE, '0, b);
        send_request(FUNC_FREE, '0, c);
        send_request(FUNC_ALLOC, REQ_W'(200), '0);
        send_request(FUNC_ALLOC, REQ_W'(4), '0);
        wait_idle();
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_HEAP_BASE;
        cfg_data     = '0;
        in_valid     = 1'b0;
        func         = FUNC_ALLOC;
        request_size = '0;
        data_address = '0;
        calm         = 1'b0;
        cur_hdr      = RST_HEADER_BYTES;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_checks();

        // defaults written back, table filled, with a long calm stretch
        run_phase(32'd24, 32'd65536, 32'hFFFF_FFFF, 400, 70, 100, 300);
        // tight limit: growth fails on the limit
        run_phase(32'd1, 32'd0, 32'd16384, 300, 60, 0, 0);
        // base near the top of the address space: growth fails on wrap
        run_phase(32'd64, 32'hFFFF_0000, 32'hFFFF_FFFF, 250, 60, 0, 0);
        // largest header value, then header and base changed over a live table
        run_phase(32'd127, 32'h8000_0000, 32'hFFFF_FFFE, 150, 60, 0, 0);
        write_reg(CFG_HEADER_BYTES, 32'd40);
        write_reg(CFG_HEAP_BASE, 32'd1234);
        for (int k = 0; k < 150; k++)
            random_request(55);
        wait_idle();
        // no header: the first block's data address is null
        run_phase(32'd0, 32'd0, 32'hFFFF_FFFF, 250, 60, 0, 0);
        // limit below the base: every growth fails
        run_phase(32'd10, 32'd1000, 32'd0, 60, 60, 0, 0);
        run_phase(32'd33, 32'h0001_0000, 32'h0002_0000, 400, 55, 0, 0);

        wait_idle();
        if (mismatches == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
